[rtl/dpc_pkg.sv]
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types and fixed field widths of the product-cost time-warping block.
// ----------------------------------------------------------------------------
`default_nettype none

package dpc_pkg;

   // Fixed widths of the stream and register fields.
   localparam int RAW_BITS      = 13;
   localparam int REQ_DATA_BITS = 16;
   localparam int CFG_BITS      = 11;

   // Codes carried in req_tuser.
   localparam logic ACT_FIRST  = 1'b0;
   localparam logic ACT_SECOND = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_SWEEP
   } state_type;

endpackage

`default_nettype wire

[rtl/dpc_ram.sv]
// ----------------------------------------------------------------------------
// dpc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module dpc_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 1024,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/dtw_product_cost.sv]
// ----------------------------------------------------------------------------
// dtw_product_cost
// Dynamic time warping over two sequences with a product local cost.
// ----------------------------------------------------------------------------
// Usage: write the sequence length on the csr channel; this also starts a new
// pair of sequences. Then send the first sequence as words with req_tuser low
// and the second with req_tuser high; raw values arrive in req_tdata and the
// weight used is the raw value minus one.
// A first-sequence word is stored as it is accepted. A second-sequence word sweeps
// one row of path costs through the row memory, one cell per cycle, over a
// read/multiply/add pipeline: from its accepting edge the block takes no
// further word until the last cell of the row has been written back.
// After the n-th second-sequence word, n being the sequence length, one result
// word appears on rsp, with the corner cost in rsp_tdata and the saturation
// flag in rsp_tuser, at the edge that writes the last cell of that row.
// It is held in an output register until rsp_tready; while it waits, and
// while a csr write is offered, req_tready stays low.
// Reset clears the counters and the flag and sets the length to one; the
// memories need no clearing, since every entry is written before it is used.
// ----------------------------------------------------------------------------
`default_nettype none

module dtw_product_cost #(
   parameter int MAX_LEN    = 1024,
   parameter int VALUE_BITS = 12,
   parameter int COST_BITS  = 40,
   localparam int RSP_DATA_BITS = ((COST_BITS + 7) / 8) * 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Requests.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [dpc_pkg::REQ_DATA_BITS-1:0] req_tdata,  // raw_value
   input  wire logic                              req_tuser,  // action
   // Results.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [RSP_DATA_BITS-1:0]          rsp_tdata,  // corner cost
   output logic                                   rsp_tuser,  // saturated
   // Configuration.
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [dpc_pkg::CFG_BITS-1:0]      csr_data    // sequence_length
);

   localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CW  = $clog2(MAX_LEN + 1);
   localparam int CLW = (dpc_pkg::CFG_BITS > CW) ? dpc_pkg::CFG_BITS : CW;
   localparam int WB  = (dpc_pkg::RAW_BITS > VALUE_BITS) ? dpc_pkg::RAW_BITS : VALUE_BITS;
   localparam int PW  = 2 * VALUE_BITS;
   localparam int XW  = (PW > COST_BITS) ? PW : COST_BITS;

   localparam logic [VALUE_BITS-1:0] WEIGHT_MAX = '1;
   localparam logic [COST_BITS-1:0]  COST_MAX   = '1;

   dpc_pkg::state_type state_ff, state_in;

   logic [CW-1:0]         len_ff;
   logic [CW-1:0]         first_count_ff;
   logic [CW-1:0]         second_count_ff;
   logic                  overflow_ff;
   logic                  first_row_ff;
   logic [VALUE_BITS-1:0] w_ff;
   logic [CW-1:0]         col_ff;
   logic                  issue_ff;

   // Pipeline: stage 1 sees memory data, stage 2 the product, stage 3 adds.
   logic                  v1_ff, v2_ff, v3_ff;
   logic [AW-1:0]         idx1_ff, idx2_ff, idx3_ff;
   logic                  fc1_ff, fc2_ff, fc3_ff;
   logic                  lc1_ff, lc2_ff, lc3_ff;
   logic [PW-1:0]         prod2_ff;
   logic [COST_BITS-1:0]  up2_ff, up3_ff;
   logic [COST_BITS-1:0]  minud2_ff, minud3_ff;
   logic [COST_BITS-1:0]  p3_ff;
   logic [COST_BITS-1:0]  left_ff;

   logic                     rsp_valid_ff;
   logic [COST_BITS-1:0]     rsp_cost_ff;
   logic                     rsp_flag_ff;

   logic                     req_fire, csr_fire;
   logic                     first_wr, start;
   logic [dpc_pkg::RAW_BITS-1:0] raw;
   logic [WB-1:0]            wdec;
   logic [VALUE_BITS-1:0]    weight;
   logic [CLW-1:0]           cfg_ext;
   logic [CW-1:0]            cfg_len;
   logic [VALUE_BITS-1:0]    w_rd;
   logic [COST_BITS-1:0]     up_rd;
   logic [XW-1:0]            prod_x;
   logic                     psat;
   logic [COST_BITS-1:0]     p_sat;
   logic [COST_BITS-1:0]     oper;
   logic [COST_BITS:0]       sum;
   logic                     add_ovf;
   logic [COST_BITS-1:0]     cost;
   logic                     row_done;
   logic                     last_issue;

   assign req_fire = req_tvalid && req_tready;
   assign csr_fire = csr_valid && csr_ready;
   // Input waits while a result is pending, so that a later pair can never
   // overwrite it, and gives way to a csr write offered in the same cycle.
   assign req_tready = (state_ff == dpc_pkg::ST_IDLE) && !rsp_valid_ff && !csr_valid;
   assign csr_ready  = (state_ff == dpc_pkg::ST_IDLE);

   // Weight is the raw value minus one, floored at zero and clamped to width.
   assign raw  = req_tdata[dpc_pkg::RAW_BITS-1:0];
   assign wdec = (raw == '0) ? '0 : WB'(raw - dpc_pkg::RAW_BITS'(1));
   assign weight = (wdec > WB'(WEIGHT_MAX)) ? WEIGHT_MAX : wdec[VALUE_BITS-1:0];

   assign cfg_ext = CLW'(csr_data);
   always_comb begin
      priority if (cfg_ext == '0) begin
         cfg_len = CW'(1);
      end else if (cfg_ext > CLW'(MAX_LEN)) begin
         cfg_len = CW'(MAX_LEN);
      end else begin
         cfg_len = cfg_ext[CW-1:0];
      end
   end

   assign first_wr = req_fire && (req_tuser == dpc_pkg::ACT_FIRST)
                     && (first_count_ff < len_ff);
   assign start    = req_fire && (req_tuser == dpc_pkg::ACT_SECOND)
                     && (first_count_ff == len_ff) && (second_count_ff < len_ff);
   assign last_issue = issue_ff && (col_ff == len_ff - CW'(1));
   assign row_done   = v3_ff && lc3_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dpc_pkg::ST_IDLE: begin
            if (start) begin
               state_in = dpc_pkg::ST_SWEEP;
            end
         end
         dpc_pkg::ST_SWEEP: begin
            if (row_done) begin
               state_in = dpc_pkg::ST_IDLE;
            end
         end
         default: state_in = dpc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dpc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   dpc_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (MAX_LEN)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (first_wr),
      .wr_addr (first_count_ff[AW-1:0]),
      .wr_data (weight),
      .rd_addr (col_ff[AW-1:0]),
      .rd_data (w_rd)
   );

   // Each cell is read as it is issued and written back from stage 3, and a row
   // finishes draining before the next one may start, so reads never see a
   // pending write.
   dpc_ram #(
      .WIDTH (COST_BITS),
      .DEPTH (MAX_LEN)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (v3_ff),
      .wr_addr (idx3_ff),
      .wr_data (cost),
      .rd_addr (col_ff[AW-1:0]),
      .rd_data (up_rd)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff          <= CW'(1);
         first_count_ff  <= '0;
         second_count_ff <= '0;
         overflow_ff     <= 1'b0;
         issue_ff        <= 1'b0;
         col_ff          <= '0;
         v1_ff           <= 1'b0;
         v2_ff           <= 1'b0;
         v3_ff           <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_fire) begin
            len_ff          <= cfg_len;
            first_count_ff  <= '0;
            second_count_ff <= '0;
            overflow_ff     <= 1'b0;
         end else begin
            if (first_wr) begin
               first_count_ff <= first_count_ff + CW'(1);
            end
            if (row_done) begin
               second_count_ff <= second_count_ff + CW'(1);
            end
            if ((v2_ff && psat) || (v3_ff && add_ovf)) begin
               overflow_ff <= 1'b1;
            end
         end

         if (start) begin
            issue_ff <= 1'b1;
            col_ff   <= '0;
         end else if (issue_ff) begin
            issue_ff <= !last_issue;
            col_ff   <= col_ff + CW'(1);
         end

         v1_ff <= issue_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;

         if (row_done && (second_count_ff + CW'(1) == len_ff)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (start) begin
         w_ff         <= weight;
         first_row_ff <= (second_count_ff == '0);
      end

      idx1_ff <= col_ff[AW-1:0];
      fc1_ff  <= (col_ff == '0);
      lc1_ff  <= last_issue;

      // The diagonal neighbor of a cell is the upper value of the cell before.
      prod2_ff  <= PW'(w_rd) * PW'(w_ff);
      up2_ff    <= up_rd;
      minud2_ff <= (up_rd < up2_ff) ? up_rd : up2_ff;
      idx2_ff   <= idx1_ff;
      fc2_ff    <= fc1_ff;
      lc2_ff    <= lc1_ff;

      p3_ff     <= p_sat;
      up3_ff    <= up2_ff;
      minud3_ff <= minud2_ff;
      idx3_ff   <= idx2_ff;
      fc3_ff    <= fc2_ff;
      lc3_ff    <= lc2_ff;

      if (v3_ff) begin
         left_ff <= cost;
      end

      if (row_done) begin
         rsp_cost_ff <= cost;
         rsp_flag_ff <= overflow_ff || add_ovf;
      end
   end

   assign prod_x = XW'(prod2_ff);
   assign psat   = (prod_x > XW'(COST_MAX));
   assign p_sat  = psat ? COST_MAX : prod_x[COST_BITS-1:0];

   // The first row accumulates along the row; the first column of later rows
   // accumulates downward.
   always_comb begin
      priority if (fc3_ff) begin
         oper = first_row_ff ? '0 : up3_ff;
      end else if (first_row_ff) begin
         oper = left_ff;
      end else begin
         oper = (left_ff < minud3_ff) ? left_ff : minud3_ff;
      end
   end

   assign sum     = {1'b0, p3_ff} + {1'b0, oper};
   assign add_ovf = sum[COST_BITS];
   assign cost    = add_ovf ? COST_MAX : sum[COST_BITS-1:0];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_cost_ff);
   assign rsp_tuser  = rsp_flag_ff;

   // A result only follows the last cell of a row.
   a_rsp_after_row: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(row_done))
      else $error("result raised without a finished row");

   // No word is taken while cells are still in flight.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (issue_ff || v1_ff || v2_ff || v3_ff) |-> !req_tready)
      else $error("word accepted during a row sweep");

   // Row counter never passes the sequence length.
   a_row_count: assert property (@(posedge clock) disable iff (reset)
      second_count_ff <= len_ff)
      else $error("row count beyond sequence length");

   // A row starts only once the whole first sequence is stored.
   a_start_loaded: assert property (@(posedge clock) disable iff (reset)
      start |-> (first_count_ff == len_ff) && (state_ff == dpc_pkg::ST_IDLE))
      else $error("row started before first sequence was complete");

endmodule

`default_nettype wire
